// ===== design/rlim_pkg.sv =====
// Shared constants and types of the per-client rate limiter.
package rlim_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned USED_W = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned KEY_W = 64;
  localparam int unsigned TS_W = 64;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned WIN_W = 40;

  localparam logic [CNT_W-1:0] RESET_MAX_REQ = 32'd60;
  localparam logic [WIN_W-1:0] RESET_WIN_US = 40'd60000000;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic REG_MAX_REQ = 1'b0;
  localparam logic REG_WIN_LEN = 1'b1;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } match_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MATCH = 5'b00010,
    ST_ENC   = 5'b00100,
    ST_READ  = 5'b01000,
    ST_RMW   = 5'b10000
  } state_e;

endpackage

// ===== design/per_client_fixed_window_rate_limiter_core.sv =====
// Per-client fixed-window rate limiter: top level with the count and window store.
// An accepted word passes through the compare, encode, memory read and
// read-modify-write steps in turn; one request is in flight at a time and the input is
// ready again only in the idle cycle after the write, so a new word is taken only once
// the last one is through, and later while a finished result word waits for the receiver.
// Reset clears the fill count and the registers to their defaults; the tables are
// not cleared, as only filled entries are ever read.
module per_client_fixed_window_rate_limiter_core
  import rlim_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // client_key[63:0], timestamp_us[127:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,   // limited[0], tracked[1], window_count[33:2], zeros
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [39:0]  cfg_data_i
);

  localparam int unsigned ENT_W = CNT_W + TS_W;

  state_e            state_d, state_q;
  logic [KEY_W-1:0]  key_q;
  logic [TS_W-1:0]   ts_q;
  logic [USED_W-1:0] used_d, used_q;
  logic [CNT_W-1:0]  max_q;
  logic [WIN_W-1:0]  win_q;
  logic              out_valid_q;
  logic [39:0]       out_data_q;

  match_t            match;
  logic [ENT_W-1:0]  ent_mem [TABLE_ENTRIES];
  logic [ENT_W-1:0]  rdata_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [ENT_W-1:0]  mem_wd;

  logic              full;
  logic              do_rmw;
  logic [TS_W-1:0]   elapsed;
  logic              restart;
  logic [CNT_W-1:0]  old_cnt, new_cnt;
  logic              limited, tracked;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  rlim_match u_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_i    (key_q),
    .used_i   (used_q),
    .wr_en_i  (do_rmw && !match.found && !full),
    .wr_idx_i (used_q[IDX_W-1:0]),
    .wr_key_i (key_q),
    .match_o  (match)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ent_mem[mem_wa] <= mem_wd;
    end
    rdata_q <= ent_mem[match.idx];
  end

  assign full    = (used_q == USED_W'(TABLE_ENTRIES));
  assign do_rmw  = (state_q == ST_RMW) && (!out_valid_q || m_axis_tready);
  assign old_cnt = rdata_q[CNT_W-1:0];
  assign elapsed = ts_q - rdata_q[ENT_W-1:CNT_W];
  assign restart = elapsed > {{(TS_W-WIN_W){1'b0}}, win_q};

  always_comb begin
    new_cnt = 32'd1;
    limited = 1'b0;
    tracked = 1'b1;
    mem_we  = 1'b0;
    mem_wa  = match.idx;
    used_d  = used_q;
    if (match.found) begin
      if (!restart) begin
        new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 32'd1;
        limited = new_cnt > max_q;
      end
      mem_we = do_rmw;
    end else if (!full) begin
      mem_we = do_rmw;
      mem_wa = used_q[IDX_W-1:0];
      if (do_rmw) begin
        used_d = used_q + USED_W'(1);
      end
    end else begin
      new_cnt = '0;
      tracked = 1'b0;
    end
    mem_wd = (match.found && !restart) ? {rdata_q[ENT_W-1:CNT_W], new_cnt} : {ts_q, new_cnt};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_MATCH;
      ST_MATCH: state_d = ST_ENC;
      ST_ENC:   state_d = ST_READ;
      ST_READ:  state_d = ST_RMW;
      ST_RMW:   if (do_rmw) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      key_q <= s_axis_tdata[63:0];
      ts_q  <= s_axis_tdata[127:64];
    end
    if (do_rmw) begin
      out_data_q <= {6'd0, new_cnt, tracked, limited};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      max_q       <= RESET_MAX_REQ;
      win_q       <= RESET_WIN_US;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (do_rmw) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_MAX_REQ: max_q <= cfg_data_i[CNT_W-1:0];
          REG_WIN_LEN: win_q <= cfg_data_i;
          default:     ;
        endcase
      end
    end
  end

endmodule

// ===== design/rlim_match.sv =====
// Client key store in flip-flops with a parallel compare and a registered encode.
module rlim_match
  import rlim_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [USED_W-1:0] used_i,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_idx_i,
  input  logic [KEY_W-1:0]  wr_key_i,
  output match_t            match_o
);

  logic [KEY_W-1:0]         keys_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] hit_d, hit_q;
  match_t                   match_d, match_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      keys_q[wr_idx_i] <= wr_key_i;
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_d[i] = (USED_W'(i) < used_i) && (keys_q[i] == key_i);
    end
  end

  // Keys in the table are unique, so at most one hit is set and an OR encode suffices.
  always_comb begin
    match_d = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit_q[i]) begin
        match_d.idx = match_d.idx | IDX_W'(i);
      end
    end
    match_d.found = |hit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= '0;
      match_q <= '0;
    end else begin
      hit_q   <= hit_d;
      match_q <= match_d;
    end
  end

  assign match_o = match_q;

endmodule
